### sv/pic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_pkg
// Shared types and constants for the PWM input capture core and its checker.
// ----------------------------------------------------------------------------
package pic_pkg;

  // field widths
  localparam int TIME_W  = 64;
  localparam int DUTY_W  = 14;
  localparam int FREQ_W  = 37;
  localparam int PROD_W  = TIME_W + DUTY_W;
  localparam int CNT_W   = 6;

  // action codes
  localparam logic [1:0] ACT_ARM     = 2'd0;
  localparam logic [1:0] ACT_RISING  = 2'd1;
  localparam logic [1:0] ACT_FALLING = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // scale constants
  localparam logic [DUTY_W-1:0] DUTY_SCALE = 14'd10000;
  localparam logic [FREQ_W-1:0] FREQ_NUM   = 37'd100000000000;

  // start values of the step counters of the serial units
  localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(DUTY_W - 1);
  localparam logic [CNT_W-1:0] DUTY_LAST = CNT_W'(DUTY_W - 1);
  localparam logic [CNT_W-1:0] FREQ_LAST = CNT_W'(FREQ_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DUTY_INIT,
    S_DIV_DUTY,
    S_FREQ_INIT,
    S_DIV_FREQ,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

### sv/pwm_input_capture_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_input_capture_core
// Measures high time, low time, period, duty and frequency of a PWM line.
// ----------------------------------------------------------------------------
// Arm, rising-edge and ignored items are taken in S_IDLE. A falling edge after
// a high phase starts a measurement: high time and period are formed as it is
// taken, S_CHECK checks them, S_MUL does a shift-add multiply by 10000, a load
// state precedes a restoring divide for duty and another one for frequency,
// then S_DONE hands the transaction to the output register once it is free. A
// zero period goes straight to S_DONE; a saturated duty skips the multiply and
// duty divide. The divider retires one quotient bit per cycle. The result
// waits in its own register, so the next item is taken while it is pending.
// ----------------------------------------------------------------------------
module pwm_input_capture_core
  import pic_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  // item channel
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire logic [1:0]        action,
  input  wire logic [TIME_W-1:0] timestamp_ns,
  input  wire logic              arm_level,
  // result channel
  output logic                   result_valid,
  input  wire logic              result_ready,
  output logic [TIME_W-1:0]      high_len,
  output logic [TIME_W-1:0]      low_len,
  output logic [TIME_W-1:0]      period_len,
  output logic [DUTY_W-1:0]      duty_hundredths,
  output logic [FREQ_W-1:0]      frequency_centihz,
  output logic                   period_zero
);

  state_t state, state_next;

  logic              last_level;
  logic [TIME_W-1:0] last_edge_time;
  logic [TIME_W-1:0] stored_low_time;

  logic [TIME_W-1:0] high_w;
  logic [TIME_W-1:0] period_w;
  logic [PROD_W-1:0] prod;
  logic [DUTY_W-1:0] mult_sr;
  logic [TIME_W-1:0] rem;
  logic [FREQ_W-1:0] num_sr;
  logic [FREQ_W-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic [DUTY_W-1:0] duty_w;
  logic [FREQ_W-1:0] freq_w;
  logic              zero_w;

  logic              accept;
  logic              out_free;
  logic [TIME_W-1:0] delta;
  logic [PROD_W-1:0] prod_next;
  logic [TIME_W:0]   shifted;
  logic [TIME_W+1:0] diff;
  logic              qbit;
  logic [TIME_W-1:0] rem_next;

  // handshake
  assign accept   = item_valid && item_ready;
  assign out_free = !result_valid || result_ready;
  assign delta    = timestamp_ns - last_edge_time;

  // shift-add multiply step, msb of the multiplier first
  assign prod_next = {prod[PROD_W-2:0], 1'b0}
                   + (mult_sr[DUTY_W-1] ? {{DUTY_W{1'b0}}, high_w} : {PROD_W{1'b0}});

  // restoring divide step
  assign shifted  = {rem, num_sr[FREQ_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, period_w};
  assign qbit     = !diff[TIME_W+1];
  assign rem_next = qbit ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and ready
  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid && action == ACT_FALLING && last_level) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (period_w == '0) begin
          state_next = S_DONE;
        end else if (high_w >= period_w) begin
          state_next = S_FREQ_INIT;
        end else begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        if (cnt == '0) state_next = S_DUTY_INIT;
      end
      S_DUTY_INIT: begin
        state_next = S_DIV_DUTY;
      end
      S_DIV_DUTY: begin
        if (cnt == '0) state_next = S_FREQ_INIT;
      end
      S_FREQ_INIT: begin
        state_next = S_DIV_FREQ;
      end
      S_DIV_FREQ: begin
        if (cnt == '0) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // line state, updated by accepted items
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level      <= 1'b0;
      last_edge_time  <= '0;
      stored_low_time <= '0;
    end else if (accept) begin
      case (action)
        ACT_ARM: begin
          last_level     <= arm_level;
          last_edge_time <= timestamp_ns;
        end
        ACT_RISING: begin
          if (!last_level) stored_low_time <= delta;
          last_level     <= 1'b1;
          last_edge_time <= timestamp_ns;
        end
        ACT_FALLING: begin
          last_level     <= 1'b0;
          last_edge_time <= timestamp_ns;
        end
        default: begin
        end
      endcase
    end
  end

  // measurement datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        high_w   <= delta;
        period_w <= delta + stored_low_time;
      end
      S_CHECK: begin
        zero_w  <= (period_w == '0);
        duty_w  <= (period_w != '0 && high_w >= period_w) ? DUTY_SCALE : '0;
        freq_w  <= '0;
        prod    <= '0;
        mult_sr <= DUTY_SCALE;
        cnt     <= MUL_LAST;
      end
      S_MUL: begin
        prod    <= prod_next;
        mult_sr <= {mult_sr[DUTY_W-2:0], 1'b0};
        cnt     <= cnt - 1'b1;
      end
      S_DUTY_INIT: begin
        // quotient fits the duty width, so the upper product bits start as remainder
        rem    <= prod[PROD_W-1:DUTY_W];
        num_sr <= {prod[DUTY_W-1:0], {(FREQ_W-DUTY_W){1'b0}}};
        quo    <= '0;
        cnt    <= DUTY_LAST;
      end
      S_DIV_DUTY: begin
        rem    <= rem_next;
        num_sr <= {num_sr[FREQ_W-2:0], 1'b0};
        quo    <= {quo[FREQ_W-2:0], qbit};
        cnt    <= cnt - 1'b1;
        if (cnt == '0) duty_w <= {quo[DUTY_W-2:0], qbit};
      end
      S_FREQ_INIT: begin
        rem    <= '0;
        num_sr <= FREQ_NUM;
        quo    <= '0;
        cnt    <= FREQ_LAST;
      end
      S_DIV_FREQ: begin
        rem    <= rem_next;
        num_sr <= {num_sr[FREQ_W-2:0], 1'b0};
        quo    <= {quo[FREQ_W-2:0], qbit};
        cnt    <= cnt - 1'b1;
        if (cnt == '0) freq_w <= {quo[FREQ_W-2:0], qbit};
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      high_len          <= high_w;
      low_len           <= stored_low_time;
      period_len        <= period_w;
      duty_hundredths   <= duty_w;
      frequency_centihz <= freq_w;
      period_zero       <= zero_w;
    end
  end

endmodule
`default_nettype wire

### sv/pic_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pic_checker
// Port-level checks for the PWM input capture core, bound into the core module.
// ----------------------------------------------------------------------------
module pic_checker
  import pic_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_valid,
  input wire logic              item_ready,
  input wire logic [1:0]        action,
  input wire logic              result_valid,
  input wire logic              result_ready,
  input wire logic [TIME_W-1:0] high_len,
  input wire logic [TIME_W-1:0] low_len,
  input wire logic [TIME_W-1:0] period_len,
  input wire logic [DUTY_W-1:0] duty_hundredths,
  input wire logic [FREQ_W-1:0] frequency_centihz,
  input wire logic              period_zero
);

  // a pending transaction is held until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid)
    else $error("result dropped before it was taken");

  // zero period gives no duty and no frequency
  a_zero_period: assert property (@(posedge clk) disable iff (rst)
    result_valid && period_zero |-> duty_hundredths == '0 && frequency_centihz == '0)
    else $error("zero period with nonzero duty or frequency");

  // duty never passes full scale
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> duty_hundredths <= DUTY_SCALE)
    else $error("duty above full scale");

  // period is the wrapped sum of the phases
  a_period_sum: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> period_len == TIME_W'(high_len + low_len))
    else $error("period is not high plus low");

  // an arm never starts a measurement
  a_arm_quiet: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && action == ACT_ARM |=> !$rose(result_valid))
    else $error("result appeared right after an arm");

endmodule

bind pwm_input_capture_core pic_checker u_pic_checker (.*);
`default_nettype wire

### verif/pwm_input_capture_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_input_capture_core_tb
// Self-checking bench for the PWM capture core. Arm and edge transactions go
// in through a valid/ready channel, and an in-bench timing predictor builds
// the expected high, low, period, duty and frequency of each closed period.
// Every measurement that leaves the core is compared with the oldest
// prediction. Directed corner cases run first, then bursts of random PWM
// waveforms with noise, a no-idle stretch and a long output stall.
// ----------------------------------------------------------------------------
module pwm_input_capture_core_tb;
  import pic_pkg::*;

  typedef struct packed {
    logic [TIME_W-1:0] high_ns;
    logic [TIME_W-1:0] low_ns;
    logic [TIME_W-1:0] per_ns;
    logic [DUTY_W-1:0] duty;
    logic [FREQ_W-1:0] freq;
    logic              zero;
  } pwm_meas_t;

  localparam logic [TIME_W-1:0] T_MAX = {TIME_W{1'b1}};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic              item_valid = 1'b0;
  logic              item_ready;
  logic [1:0]        action = ACT_ARM;
  logic [TIME_W-1:0] timestamp_ns = '0;
  logic              arm_level = 1'b0;

  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [TIME_W-1:0] high_len;
  logic [TIME_W-1:0] low_len;
  logic [TIME_W-1:0] period_len;
  logic [DUTY_W-1:0] duty_hundredths;
  logic [FREQ_W-1:0] frequency_centihz;
  logic              period_zero;

  // predictor state, mirrors the core after reset
  logic              line_lvl = 1'b0;
  logic [TIME_W-1:0] last_stamp = '0;
  logic [TIME_W-1:0] low_span = '0;

  pwm_meas_t pending_meas[$];

  // traffic control and statistics
  bit src_gaps_on = 1'b1;
  bit sink_stalls_on = 1'b1;
  int sink_hold_req = 0;
  int items_by_act[4];
  int items_counted = 0;
  int meas_ok = 0;
  int meas_bad = 0;
  int meas_zero = 0;
  int meas_sat = 0;

  pwm_input_capture_core i_dut (
    .clk               (clk),
    .rst               (rst),
    .item_valid        (item_valid),
    .item_ready        (item_ready),
    .action            (action),
    .timestamp_ns      (timestamp_ns),
    .arm_level         (arm_level),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .high_len          (high_len),
    .low_len           (low_len),
    .period_len        (period_len),
    .duty_hundredths   (duty_hundredths),
    .frequency_centihz (frequency_centihz),
    .period_zero       (period_zero)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // timing predictor: updates line state and queues a measurement on each
  // falling edge that closes a high phase
  task automatic track_edge(input logic [1:0] act, input logic [TIME_W-1:0] ts,
                            input logic lvl);
    logic [TIME_W-1:0] span;
    logic [2*TIME_W-1:0] scaled;
    pwm_meas_t m;
    span = ts - last_stamp;
    items_by_act[act]++;
    case (act)
      ACT_ARM: begin
        line_lvl = lvl;
        last_stamp = ts;
      end
      ACT_RISING: begin
        if (!line_lvl) low_span = span;
        line_lvl = 1'b1;
        last_stamp = ts;
      end
      ACT_FALLING: begin
        if (line_lvl) begin
          m.high_ns = span;
          m.low_ns = low_span;
          m.per_ns = span + low_span;
          m.zero = (m.per_ns == '0);
          m.duty = '0;
          m.freq = '0;
          if (m.zero) begin
            meas_zero++;
          end else begin
            // a wrapped sum can leave high above the period
            if (m.high_ns >= m.per_ns) begin
              m.duty = DUTY_SCALE;
              meas_sat++;
            end else begin
              scaled = ({{TIME_W{1'b0}}, m.high_ns} * DUTY_SCALE) /
                       {{TIME_W{1'b0}}, m.per_ns};
              m.duty = scaled[DUTY_W-1:0];
            end
            m.freq = FREQ_W'({{(TIME_W-FREQ_W){1'b0}}, FREQ_NUM} / m.per_ns);
          end
          pending_meas.push_back(m);
        end
        line_lvl = 1'b0;
        last_stamp = ts;
      end
      default: ;
    endcase
  endtask

  // one transaction on the item channel; entered and left at a falling edge
  task automatic send_item(input logic [1:0] act, input logic [TIME_W-1:0] ts,
                           input logic lvl);
    while (src_gaps_on && $urandom_range(99) < 21) begin
      item_valid = 1'b0;
      @(negedge clk);
    end
    item_valid = 1'b1;
    action = act;
    timestamp_ns = ts;
    arm_level = lvl;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    track_edge(act, ts, lvl);
    if (act != ACT_NONE) items_counted++;
    @(negedge clk);
  endtask

  task automatic wait_meas_drained();
    item_valid = 1'b0;
    while (pending_meas.size() != 0) @(negedge clk);
    // a falling edge after low gives nothing, so let the core settle
    repeat (100) @(negedge clk);
  endtask

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // phase length spread over several magnitudes
  function automatic logic [TIME_W-1:0] pick_span();
    case ($urandom_range(9))
      0:       return '0;
      1:       return TIME_W'($urandom_range(3, 1));
      2, 3, 4: return TIME_W'($urandom_range(100000, 1));
      5, 6:    return TIME_W'($urandom);
      7:       return {24'd0, 8'($urandom), $urandom};
      default: return rand64();
    endcase
  endfunction

  // broken sequences: ignored code, stray edge, time jump or re-arm
  task automatic inject_noise(inout logic [TIME_W-1:0] t);
    case ($urandom_range(3))
      0: send_item(ACT_NONE, rand64(), 1'($urandom));
      1: begin
        t += pick_span();
        send_item($urandom_range(1) ? ACT_RISING : ACT_FALLING, t, 1'($urandom));
      end
      2: begin
        t = rand64();
        send_item($urandom_range(1) ? ACT_RISING : ACT_FALLING, t, 1'($urandom));
      end
      default: send_item(ACT_ARM, t, 1'($urandom));
    endcase
  endtask

  // arm, then a run of alternating edges
  task automatic pwm_burst(input int periods);
    logic [TIME_W-1:0] t;
    logic lvl;
    int k;
    t = ($urandom_range(3) == 0) ? rand64() : TIME_W'($urandom);
    lvl = 1'($urandom);
    send_item(ACT_ARM, t, lvl);
    for (k = 0; k < 2 * periods; k++) begin
      if ($urandom_range(19) == 0) inject_noise(t);
      t += pick_span();
      send_item(lvl ? ACT_FALLING : ACT_RISING, t, 1'($urandom));
      lvl = !lvl;
    end
  endtask

  // edges measured against the reset time and level
  task automatic test_edge_before_arm();
    send_item(ACT_RISING, 64'd100, 1'b0);
    send_item(ACT_FALLING, 64'd350, 1'b1);
  endtask

  task automatic test_zero_period();
    send_item(ACT_ARM, 64'd5000, 1'b0);
    send_item(ACT_RISING, 64'd5000, 1'b0);
    send_item(ACT_FALLING, 64'd5000, 1'b0);
  endtask

  // low time at full scale, so the period sum wraps below the high time
  task automatic test_wrapped_period();
    send_item(ACT_ARM, 64'd0, 1'b0);
    send_item(ACT_RISING, T_MAX, 1'b1);
    send_item(ACT_FALLING, 64'd4, 1'b0);
  endtask

  // edges that do not match the line level, and the ignored code
  task automatic test_unmatched_edges();
    send_item(ACT_ARM, 64'd10, 1'b1);
    send_item(ACT_RISING, 64'd20, 1'b0);
    send_item(ACT_ARM, 64'd30, 1'b0);
    send_item(ACT_FALLING, 64'd40, 1'b1);
    send_item(ACT_NONE, rand64(), 1'b1);
    send_item(ACT_RISING, 64'd50, 1'b0);
    send_item(ACT_FALLING, 64'd60, 1'b0);
  endtask

  // shortest and longest periods, timestamps at both ends of the range
  task automatic test_extreme_periods();
    send_item(ACT_ARM, T_MAX, 1'b0);
    send_item(ACT_RISING, T_MAX, 1'b0);
    send_item(ACT_FALLING, 64'd0, 1'b1);
    send_item(ACT_ARM, 64'd0, 1'b0);
    send_item(ACT_RISING, 64'd1, 1'b0);
    send_item(ACT_FALLING, 64'd1, 1'b0);
    send_item(ACT_ARM, 64'd0, 1'b0);
    send_item(ACT_RISING, 64'h8000_0000_0000_0000, 1'b1);
    send_item(ACT_FALLING, T_MAX, 1'b1);
  endtask

  task automatic test_back_to_back();
    int start;
    start = items_counted;
    src_gaps_on = 1'b0;
    sink_stalls_on = 1'b0;
    while (items_counted - start < 80) pwm_burst(4);
    wait_meas_drained();
    src_gaps_on = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  // output held off while the sender keeps offering full periods
  task automatic test_output_backpressure();
    sink_hold_req = 600;
    pwm_burst(12);
    wait_meas_drained();
  endtask

  task automatic test_random_pwm();
    int start;
    start = items_counted;
    while (items_counted - start < 460) pwm_burst($urandom_range(8, 1));
  endtask

  // receiver: random stalls, or one long hold counted here
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (sink_hold_req != 0) begin
        hold_left = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        result_ready = 1'b0;
        hold_left--;
      end else begin
        result_ready = !(sink_stalls_on && $urandom_range(99) < 21);
      end
    end
  end

  // compare each measurement transaction with the oldest prediction
  always @(posedge clk) begin
    pwm_meas_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_meas.size() == 0) begin
        meas_bad++;
        if (meas_bad <= 10)
          $display("unexpected measurement: high %0d low %0d period %0d",
                   high_len, low_len, period_len);
      end else begin
        want = pending_meas.pop_front();
        if (high_len !== want.high_ns || low_len !== want.low_ns ||
            period_len !== want.per_ns || duty_hundredths !== want.duty ||
            frequency_centihz !== want.freq || period_zero !== want.zero) begin
          meas_bad++;
          if (meas_bad <= 10) begin
            $display("mismatch exp: high %0d low %0d period %0d duty %0d freq %0d zero %0d",
                     want.high_ns, want.low_ns, want.per_ns, want.duty, want.freq,
                     want.zero);
            $display("         got: high %0d low %0d period %0d duty %0d freq %0d zero %0d",
                     high_len, low_len, period_len, duty_hundredths,
                     frequency_centihz, period_zero);
          end
        end else begin
          meas_ok++;
        end
      end
    end
  end

  // main sequence
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_edge_before_arm();
    test_zero_period();
    test_wrapped_period();
    test_unmatched_edges();
    test_extreme_periods();
    wait_meas_drained();
    test_back_to_back();
    test_output_backpressure();
    test_random_pwm();
    wait_meas_drained();
    repeat (50) @(negedge clk);
    if (pending_meas.size() != 0) begin
      meas_bad++;
      $display("%0d measurements never arrived", pending_meas.size());
    end
    $display("covered %0d arm, %0d rising, %0d falling and %0d ignored transactions",
             items_by_act[ACT_ARM], items_by_act[ACT_RISING], items_by_act[ACT_FALLING],
             items_by_act[ACT_NONE]);
    $display("checked %0d measurements, %0d zero period, %0d saturated duty",
             meas_ok + meas_bad, meas_zero, meas_sat);
    if (meas_bad == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule
